// File: design/mfcs_pkg.sv
// Shared types, widths and span codes for the midpoint filled-circle span core.
// No dependencies; imported by every module of the core.
package mfcs_pkg;

    localparam int COORD_BITS  = 10;               // center coordinate width
    localparam int RADIUS_BITS = 8;                // radius width actually used
    localparam int OFF_W       = RADIUS_BITS + 2;  // signed offsets, y may reach -1
    localparam int DEC_W       = RADIUS_BITS + 4;  // signed decision value
    localparam int OUT_W       = 12;               // span coordinate width
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(30);

    // register indexes
    localparam logic REG_RADIUS = 1'b0;

    // request codes
    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    // span order within one run of four
    localparam logic [1:0] SPAN_XY  = 2'd0;   // ( x,  y)
    localparam logic [1:0] SPAN_NXY = 2'd1;   // (-x,  y)
    localparam logic [1:0] SPAN_NYX = 2'd2;   // (-y,  x)
    localparam logic [1:0] SPAN_YX  = 2'd3;   // ( y,  x), flagged last

    // one run of four spans as handed from front to back
    typedef struct packed {
        logic [COORD_BITS-1:0]   cx;
        logic [COORD_BITS-1:0]   cy;
        logic signed [OFF_W-1:0] x;
        logic signed [OFF_W-1:0] y;
        logic                    done;
    } t_run;

endpackage

// File: design/mfcs_front.sv
// Front end: accepts requests, holds the circle state and does one midpoint step.
// Depends on mfcs_pkg; pushes one t_run per emitting request into mfcs_queue.
module mfcs_front
    import mfcs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [RADIUS_BITS-1:0] i_radius,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_req_type,
    input  logic [COORD_BITS-1:0]  i_center_x,
    input  logic [COORD_BITS-1:0]  i_center_y,
    input  logic                   i_q_full,
    output logic                   o_push,
    output t_run                   o_run
);

    logic                    r_running, n_running;
    logic signed [OFF_W-1:0] r_x, n_x;
    logic signed [OFF_W-1:0] r_y, n_y;
    logic signed [DEC_W-1:0] r_d, n_d;
    logic [COORD_BITS-1:0]   r_cx, n_cx;
    logic [COORD_BITS-1:0]   r_cy, n_cy;

    logic                    accept;
    logic signed [OFF_W-1:0] x1, y1, rad_s;
    logic signed [DEC_W-1:0] dstep;
    logic                    done;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign rad_s   = $signed({2'b00, i_radius});

    always_comb begin
        x1 = r_x + OFF_W'(1);
        y1 = (r_d < 0) ? r_y : (r_y - OFF_W'(1));
        dstep = (DEC_W'(x1) <<< 1) + DEC_W'(1);
        if (r_d >= 0) begin
            dstep = dstep - (DEC_W'(y1) <<< 1);
        end
        done = (x1 > y1);
    end

    always_comb begin
        n_running = r_running;
        n_x       = r_x;
        n_y       = r_y;
        n_d       = r_d;
        n_cx      = r_cx;
        n_cy      = r_cy;
        o_push    = 1'b0;
        o_run     = '0;
        if (accept) begin
            case (i_req_type)
                REQ_START: begin
                    n_cx      = i_center_x;
                    n_cy      = i_center_y;
                    n_x       = '0;
                    n_y       = rad_s;
                    n_d       = DEC_W'(1) - DEC_W'(rad_s);
                    n_running = 1'b1;
                    o_push    = 1'b1;
                    o_run     = '{cx: i_center_x, cy: i_center_y, x: '0, y: rad_s,
                                  done: 1'b0};
                end
                REQ_ADVANCE: begin
                    if (r_running) begin
                        n_x       = x1;
                        n_y       = y1;
                        n_d       = r_d + dstep;
                        n_running = !done;
                        o_push    = 1'b1;
                        o_run     = '{cx: r_cx, cy: r_cy, x: x1, y: y1, done: done};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_x       <= '0;
            r_y       <= '0;
            r_d       <= '0;
            r_cx      <= '0;
            r_cy      <= '0;
        end else begin
            r_running <= n_running;
            r_x       <= n_x;
            r_y       <= n_y;
            r_d       <= n_d;
            r_cx      <= n_cx;
            r_cy      <= n_cy;
        end
    end

endmodule

// File: design/mfcs_queue.sv
// Short flop-based FIFO of t_run records between front and back.
// Depends on mfcs_pkg (t_run, QUEUE_DEPTH).
module mfcs_queue
    import mfcs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_run i_data,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_run o_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_run          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: design/mfcs_back.sv
// Back end: expands one t_run into four spans, one per cycle unless stalled, into an output register.
// Depends on mfcs_pkg; pops records from mfcs_queue.
module mfcs_back
    import mfcs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  t_run                  i_q_data,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [OUT_W-1:0] o_span_column,
    output logic signed [OUT_W-1:0] o_span_top,
    output logic signed [OUT_W-1:0] o_span_bottom,
    output logic                  o_last_of_run,
    output logic                  o_circle_done
);

    localparam int SW0  = (COORD_BITS > OFF_W) ? COORD_BITS : OFF_W;
    localparam int SUMW = ((SW0 + 2) > OUT_W) ? (SW0 + 2) : OUT_W;

    t_run       r_run;
    logic       r_have;
    logic [1:0] r_idx;
    logic       r_oval;
    logic signed [OUT_W-1:0] r_col, r_top, r_bot;
    logic       r_last, r_done;

    logic                    out_free, load_span, idx_last;
    logic signed [OFF_W-1:0] dx, dy;
    logic signed [SUMW-1:0]  cx_s, cy_s, col_s, top_s, bot_s;

    assign out_free  = !r_oval || i_ready;
    assign load_span = out_free && r_have;
    assign idx_last  = (r_idx == SPAN_YX);
    assign o_pop     = i_q_valid && (!r_have || (load_span && idx_last));

    always_comb begin
        case (r_idx)
            SPAN_XY:  begin dx = r_run.x;  dy = r_run.y; end
            SPAN_NXY: begin dx = -r_run.x; dy = r_run.y; end
            SPAN_NYX: begin dx = -r_run.y; dy = r_run.x; end
            SPAN_YX:  begin dx = r_run.y;  dy = r_run.x; end
            default:  begin dx = r_run.x;  dy = r_run.y; end
        endcase
        cx_s  = $signed({{(SUMW-COORD_BITS){1'b0}}, r_run.cx});
        cy_s  = $signed({{(SUMW-COORD_BITS){1'b0}}, r_run.cy});
        col_s = cx_s + SUMW'(dx);
        top_s = cy_s + SUMW'(dy);
        bot_s = cy_s - SUMW'(dy);
    end

    // record and span counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_idx  <= SPAN_XY;
        end else if (o_pop) begin
            r_have <= 1'b1;
            r_idx  <= SPAN_XY;
        end else if (load_span) begin
            r_have <= !idx_last;
            r_idx  <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_run <= i_q_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (load_span) begin
            r_oval <= 1'b1;
        end else if (i_ready) begin
            r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_span) begin
            r_col  <= col_s[OUT_W-1:0];
            r_top  <= top_s[OUT_W-1:0];
            r_bot  <= bot_s[OUT_W-1:0];
            r_last <= idx_last;
            r_done <= r_run.done;
        end
    end

    assign o_valid       = r_oval;
    assign o_span_column = r_col;
    assign o_span_top    = r_top;
    assign o_span_bottom = r_bot;
    assign o_last_of_run = r_last;
    assign o_circle_done = r_done;

endmodule

// File: design/midpoint_filled_circle_spans_core.sv
// Top level of the midpoint filled-circle span core: APB radius register,
// front end, run queue and span back end. Depends on mfcs_pkg and all mfcs_* modules.
//
//  channel    | handshake            | payload
//  -----------+----------------------+----------------------------------------------
//  request in | i_valid / o_ready    | i_req_type, i_center_x, i_center_y
//  spans out  | o_valid / i_ready    | o_span_column/top/bottom, o_last_of_run,
//             |                      | o_circle_done
//  config     | psel/penable/pwrite  | paddr, pwdata, prdata (radius at 0x0)
//
// Flow: the front does one midpoint step per accepted request combinationally and
//   registers the new state; the back emits one span per cycle while i_ready allows,
//   four per start or live advance, and the run queue lets new requests be accepted
//   while earlier runs are still expanding. An advance on an idle circle is absorbed
//   with no beats. A run passes the queue entry, record register and output register.
// Reset: synchronous, active low; radius returns to 30, the circle goes idle.
// Stalls: a two-deep run queue decouples the sides; o_ready drops only when it is
//   full, and a stalled output beat holds in the output register.
module midpoint_filled_circle_spans_core
    import mfcs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // request channel
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_req_type,
    input  logic [COORD_BITS-1:0]   i_center_x,
    input  logic [COORD_BITS-1:0]   i_center_y,
    // span channel
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [OUT_W-1:0] o_span_column,
    output logic signed [OUT_W-1:0] o_span_top,
    output logic signed [OUT_W-1:0] o_span_bottom,
    output logic                    o_last_of_run,
    output logic                    o_circle_done,
    // APB config
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_AW-1:0]       paddr,
    input  logic [APB_DW-1:0]       pwdata,
    output logic [APB_DW-1:0]       prdata,
    output logic                    pready
);

    logic [RADIUS_BITS-1:0] r_radius;
    logic                   reg_idx;
    logic                   cfg_wr;

    logic q_full, q_push, q_valid, q_pop;
    t_run q_in, q_out;

    // ---- config register: word index taken from the byte address ----
    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (cfg_wr && (reg_idx == REG_RADIUS)) begin
            r_radius <= pwdata[RADIUS_BITS-1:0];
        end
    end

    assign prdata = (reg_idx == REG_RADIUS) ? APB_DW'(r_radius) : '0;

    // ---- front: accept, step, push runs ----
    mfcs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_radius   (r_radius),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_run      (q_in)
    );

    // ---- run queue ----
    mfcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_out)
    );

    // ---- back: four span beats per run ----
    mfcs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_data      (q_out),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_span_column (o_span_column),
        .o_span_top    (o_span_top),
        .o_span_bottom (o_span_bottom),
        .o_last_of_run (o_last_of_run),
        .o_circle_done (o_circle_done)
    );

endmodule

// File: sim/tb_midpoint_filled_circle_spans_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for midpoint_filled_circle_spans_core: start/advance requests,
// radius register over APB, and a cycle-free model of the midpoint walk checking each beat.
// Depends on mfcs_pkg and the core RTL only.
module tb_midpoint_filled_circle_spans_core;
    import mfcs_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int IDLE_PCT      = 32;     // chance per cycle that a side idles
    localparam int HOLD_CYCLES   = 160;    // long span-side hold-off
    localparam int QUIET_LIMIT   = 3000;   // cycles with no beat anywhere before giving up
    localparam int SETTLE_CYCLES = 8;      // leave slack for idle advances
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_ITEMS  = 200;
    localparam int REG_SPARE     = 1;      // unmapped register slot, writes must be dropped

    // one expected span beat
    typedef struct {
        logic signed [OUT_W-1:0] column;
        logic signed [OUT_W-1:0] top;
        logic signed [OUT_W-1:0] bottom;
        logic                    last_of_run;
        logic                    circle_done;
    } t_span;

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic                    i_req_type;
    logic [COORD_BITS-1:0]   i_center_x;
    logic [COORD_BITS-1:0]   i_center_y;
    logic                    o_valid;
    logic                    i_ready;
    logic signed [OUT_W-1:0] o_span_column;
    logic signed [OUT_W-1:0] o_span_top;
    logic signed [OUT_W-1:0] o_span_bottom;
    logic                    o_last_of_run;
    logic                    o_circle_done;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_AW-1:0]       paddr;
    logic [APB_DW-1:0]       pwdata;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;

    midpoint_filled_circle_spans_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_span_column (o_span_column),
        .o_span_top    (o_span_top),
        .o_span_bottom (o_span_bottom),
        .o_last_of_run (o_last_of_run),
        .o_circle_done (o_circle_done),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ------------------------------------------------------------------
    // Circle walk model: its own radius copy, latched center, offsets and
    // decision value, kept at the core's widths. Updated at request accept.
    // ------------------------------------------------------------------
    logic [RADIUS_BITS-1:0]  radius_reg  = RADIUS_RESET;
    logic [COORD_BITS-1:0]   ctr_x       = '0;
    logic [COORD_BITS-1:0]   ctr_y       = '0;
    logic signed [OFF_W-1:0] walk_x      = '0;
    logic signed [OFF_W-1:0] walk_y      = '0;
    logic signed [DEC_W-1:0] walk_d      = '0;
    logic                    walking     = 1'b0;
    t_span                   span_q[$];   // spans owed by the core, oldest first

    // bookkeeping
    int mismatches     = 0;
    int items_sent     = 0;   // requests that produced spans
    int idle_advances  = 0;   // advances absorbed with no spans
    int spans_seen     = 0;
    int circles_closed = 0;
    int radii_tried    = 0;

    // side controls
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int hold_req   = 0;       // bumped by the stimulus to ask for a hold-off
    int hold_seen  = 0;
    int hold_left  = 0;
    int quiet_cycles = 0;

    function automatic void push_span(int dx, int dy, logic last_f, logic done_f);
        t_span s;
        s.column      = OUT_W'(int'(ctr_x) + dx);
        s.top         = OUT_W'(int'(ctr_y) + dy);
        s.bottom      = OUT_W'(int'(ctr_y) - dy);
        s.last_of_run = last_f;
        s.circle_done = done_f;
        span_q.push_back(s);
    endfunction

    // four spans per run: (x,y) (-x,y) (-y,x) (y,x); only the fourth is flagged last
    function automatic void push_run(logic done_f);
        push_span( int'(walk_x), int'(walk_y), 1'b0, done_f);
        push_span(-int'(walk_x), int'(walk_y), 1'b0, done_f);
        push_span(-int'(walk_y), int'(walk_x), 1'b0, done_f);
        push_span( int'(walk_y), int'(walk_x), 1'b1, done_f);
    endfunction

    // returns the number of spans the request owes
    function automatic int walk_request(logic req, logic [COORD_BITS-1:0] cx,
                                        logic [COORD_BITS-1:0] cy);
        int   d;
        logic done_f;
        done_f = 1'b0;
        if (req == REQ_START) begin
            // a start abandons whatever circle was running
            ctr_x   = cx;
            ctr_y   = cy;
            walk_x  = '0;
            walk_y  = OFF_W'(radius_reg);
            walk_d  = DEC_W'(1 - int'(radius_reg));
            walking = 1'b1;
        end else begin
            if (!walking)
                return 0;
            walk_x = walk_x + OFF_W'(1);
            d = int'(walk_d);
            if (d < 0) begin
                d = d + 2 * int'(walk_x) + 1;
            end else begin
                walk_y = walk_y - OFF_W'(1);
                d = d + 2 * int'(walk_x) + 1 - 2 * int'(walk_y);
            end
            walk_d = DEC_W'(d);
            // radius zero ends here with y = -1: top below bottom, as the rule gives
            if (walk_x > walk_y) begin
                walking = 1'b0;
                done_f  = 1'b1;
            end
        end
        push_run(done_f);
        return 4;
    endfunction

    function automatic logic [COORD_BITS-1:0] pick_coord();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return '0;
        if (r < 10)
            return '1;
        return COORD_BITS'($urandom_range((1 << COORD_BITS) - 1));
    endfunction

    task automatic note_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH: %s", what);
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Span side: i_ready changes on the falling edge. A hold-off request
    // from the stimulus is latched here and counted down locally.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready = 1'b0;
        end else if (rx_idle_on) begin
            i_ready = ($urandom_range(99) >= IDLE_PCT);
        end else begin
            i_ready = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Span checker: every beat taken at a rising edge is matched against the
    // oldest owed span, all five fields at once, both sides printed.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_span want;
        if (i_rst_n && o_valid && i_ready) begin
            spans_seen++;
            if (o_last_of_run && o_circle_done)
                circles_closed++;
            if (span_q.size() == 0) begin
                note_mismatch($sformatf("beat %0d with nothing owed: col %0d top %0d bot %0d",
                                        spans_seen, o_span_column, o_span_top,
                                        o_span_bottom));
            end else begin
                want = span_q.pop_front();
                if ({o_span_column, o_span_top, o_span_bottom, o_last_of_run, o_circle_done}
                    !== {want.column, want.top, want.bottom, want.last_of_run,
                         want.circle_done})
                    note_mismatch($sformatf(
                        "beat %0d exp col %0d top %0d bot %0d last %b done %b, got %0d %0d %0d %b %b",
                        spans_seen, want.column, want.top, want.bottom, want.last_of_run,
                        want.circle_done, o_span_column, o_span_top, o_span_bottom,
                        o_last_of_run, o_circle_done));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any request, span or register beat keeps it quiet.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: %0d cycles without a beat, %0d spans still owed",
                     quiet_cycles, span_q.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // One request beat: optional random idle, then valid held until accepted.
    // Valid stays high on return so back-to-back beats need no drop.
    task automatic send_request(logic req, logic [COORD_BITS-1:0] cx,
                                logic [COORD_BITS-1:0] cy);
        @(negedge i_clk);
        if (tx_idle_on) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_valid = 1'b0;
                @(negedge i_clk);
            end
        end
        i_valid    = 1'b1;
        i_req_type = req;
        i_center_x = cx;
        i_center_y = cy;
        do @(posedge i_clk); while (!o_ready);
        if (walk_request(req, cx, cy) == 0)
            idle_advances++;
        else
            items_sent++;
    endtask

    // Sender pause: nothing offered until every owed span has come back,
    // then waits out SETTLE_CYCLES, since an idle advance may still be in flight.
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (span_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(int idx, logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = APB_AW'(4 * idx);
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == int'(REG_RADIUS))
            radius_reg = value[RADIUS_BITS-1:0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read_check(int idx, logic [APB_DW-1:0] want);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b0;
        penable = 1'b0;
        paddr   = APB_AW'(4 * idx);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want)
            note_mismatch($sformatf("register %0d read: expected %h, got %h",
                                    idx, want, prdata));
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_radius(logic [APB_DW-1:0] value);
        wait_drained();
        apb_write(int'(REG_RADIUS), value);
        radii_tried++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // advances before any start must be swallowed without spans
    task automatic test_idle_advance();
        send_request(REQ_ADVANCE, '1, '1);
        send_request(REQ_ADVANCE, '0, '0);
    endtask

    // reset radius of 30 is used by a start with no register write
    task automatic test_reset_radius();
        send_request(REQ_START, 10'd512, 10'd300);
        repeat (3) send_request(REQ_ADVANCE, pick_coord(), pick_coord());
    endtask

    // read back, writes to the unmapped slot are dropped, upper data bits ignored
    task automatic test_register_access();
        wait_drained();
        apb_read_check(int'(REG_RADIUS), APB_DW'(RADIUS_RESET));
        apb_write(REG_SPARE, 32'h0000_00AB);
        apb_read_check(int'(REG_RADIUS), APB_DW'(radius_reg));
        apb_write(int'(REG_RADIUS), 32'hFFFF_FF07);
        apb_read_check(int'(REG_RADIUS), APB_DW'(radius_reg));
        radii_tried++;
        send_request(REQ_START, 10'd100, 10'd900);
        repeat (2) send_request(REQ_ADVANCE, pick_coord(), pick_coord());
    endtask

    // radius zero at the origin: one-pixel spans, then a single closing step
    // with negative rows, then an advance on the finished circle
    task automatic test_radius_zero();
        set_radius(32'd0);
        send_request(REQ_START, '0, '0);
        send_request(REQ_ADVANCE, '0, '0);
        send_request(REQ_ADVANCE, '1, '1);
    endtask

    task automatic test_radius_one();
        set_radius(32'd1);
        send_request(REQ_START, '1, '0);
        send_request(REQ_ADVANCE, '1, '1);
    endtask

    // largest radius at opposite corners: columns well below zero and past 1023
    task automatic test_radius_max();
        set_radius(32'd255);
        send_request(REQ_START, '0, '1);
        send_request(REQ_ADVANCE, '0, '0);
        send_request(REQ_START, '1, '0);
        send_request(REQ_ADVANCE, '1, '1);
    endtask

    task automatic test_restart_mid_circle();
        set_radius(32'd5);
        send_request(REQ_START, 10'd40, 10'd700);
        send_request(REQ_ADVANCE, '0, '0);
        send_request(REQ_ADVANCE, '0, '0);
        send_request(REQ_START, 10'd900, 10'd15);
        send_request(REQ_ADVANCE, '0, '0);
    endtask

    // span side held off long while requests keep coming: the run queue
    // fills and o_ready must drop without losing anything
    task automatic test_backpressure();
        set_radius(32'd20);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_req++;
        send_request(REQ_START, pick_coord(), pick_coord());
        repeat (15) send_request(REQ_ADVANCE, pick_coord(), pick_coord());
        wait_drained();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // mostly complete circles on small radii with random centers; some
    // abandoned mid-walk, a few large radii cut short, stray advances as noise
    task automatic test_random_walks();
        int          first_item;
        int          phase;
        int          r;
        int          steps_left;
        logic [7:0]  rad;
        logic [31:0] wdata;
        first_item = items_sent;
        phase = 0;
        while (items_sent - first_item < RANDOM_ITEMS) begin
            r = $urandom_range(99);
            if (r < 70)
                rad = 8'($urandom_range(12));
            else if (r < 90)
                rad = 8'($urandom_range(13, 40));
            else
                rad = 8'($urandom_range(200, 255));
            wdata = $urandom;
            wdata[7:0] = rad;
            if ($urandom_range(3) != 0)
                wdata[31:8] = '0;
            wait_drained();
            if ($urandom_range(4) == 0)
                apb_write(REG_SPARE, $urandom);
            set_radius(wdata);
            // one phase runs with both sides streaming, no idle cycles at all
            tx_idle_on = (phase != 2);
            rx_idle_on = (phase != 2);
            repeat ($urandom_range(1, 3)) begin
                send_request(REQ_START, pick_coord(), pick_coord());
                steps_left = (rad > 40) ? $urandom_range(2, 10) : 1000;
                while (walking && steps_left > 0) begin
                    if ($urandom_range(99) < 6)
                        break;
                    send_request(REQ_ADVANCE, pick_coord(), pick_coord());
                    steps_left--;
                end
                if ($urandom_range(99) < 20)
                    send_request(REQ_ADVANCE, pick_coord(), pick_coord());
            end
            phase++;
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_req_type = REQ_START;
        i_center_x = '0;
        i_center_y = '0;
        i_ready    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_idle_advance();
        test_reset_radius();
        test_register_access();
        test_radius_zero();
        test_radius_one();
        test_radius_max();
        test_restart_mid_circle();
        test_backpressure();
        test_random_walks();
        wait_drained();

        $display("covered %0d span-producing requests and %0d idle advances over %0d radii",
                 items_sent, idle_advances, radii_tried);
        $display("checked %0d span beats, %0d circles walked to the end, %0d mismatches",
                 spans_seen, circles_closed, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
